// ===== hw/rtl/bgcd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bgcd_pkg;

   // operand and result width
   localparam int DataWidth = 32;
   // shared factor-of-two count never exceeds DataWidth - 1
   localparam int ShiftWidth = $clog2(DataWidth);

   // controller to datapath
   typedef struct packed {
      logic load;    // take a new operand pair
      logic step;    // run one reduction step
      logic finish;  // register the shifted result
   } bgcd_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic done;    // a terminal case is reached
   } bgcd_sts_type;

endpackage

`default_nettype wire

// ===== hw/rtl/binary_gcd.sv =====
// a start transfer loads the operands, n reduction steps follow until a terminal case,
//   whose cycle registers the result and raises rsp_valid (each step halves an operand
//   or replaces one by half the difference); n is at most about 2 * DataWidth
// no new start is taken during a run; the next start is taken while rsp_valid is high
// reset (synchronous, active high) returns the controller to idle with no result pending
// results cannot be stalled; rsp_divisor holds until the next result is registered
`timescale 1ns / 1ps
`default_nettype none

module binary_gcd
   import bgcd_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   // request transfer: start while busy is low
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic [DataWidth-1:0] req_operand_a,
   input  wire logic [DataWidth-1:0] req_operand_b,
   // result transfer: one-cycle strobe
   output logic                      rsp_valid,
   output logic      [DataWidth-1:0] rsp_divisor
);

   bgcd_cmd_type cmd;
   bgcd_sts_type sts;

   // controller: idle/run sequencing, one reduction step per cycle while running,
   // result strobe the cycle after the terminal case is seen
   bgcd_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .sts    (sts),
      .cmd    (cmd),
      .busy   (busy),
      .strobe (rsp_valid)
   );

   // datapath: operand registers, shared power-of-two count, terminal detect,
   // one subtract and compare per step, final left shift into the result register
   bgcd_dp u_dp (
      .clock     (clock),
      .cmd       (cmd),
      .operand_a (req_operand_a),
      .operand_b (req_operand_b),
      .sts       (sts),
      .divisor   (rsp_divisor)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/bgcd_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bgcd_dp
   import bgcd_pkg::*;
(
   input  wire logic                 clock,
   input  wire bgcd_cmd_type         cmd,
   input  wire logic [DataWidth-1:0] operand_a,
   input  wire logic [DataWidth-1:0] operand_b,
   output bgcd_sts_type              sts,
   output logic      [DataWidth-1:0] divisor
);

   logic [DataWidth-1:0]  x_ff, x_in;
   logic [DataWidth-1:0]  y_ff, y_in;
   logic [ShiftWidth-1:0] shared_ff, shared_in;
   logic [DataWidth-1:0]  result_ff, result_in;

   logic                 any_zero, any_one, same, y_larger;
   logic [DataWidth-1:0] base;

   always_comb begin
      any_zero = (x_ff == '0) || (y_ff == '0);
      any_one  = (x_ff == DataWidth'(1)) || (y_ff == DataWidth'(1));
      same     = (x_ff == y_ff);
      y_larger = (y_ff > x_ff);
      sts.done = any_zero || any_one || same;

      // value found in the terminal case, before the shared shift
      if (any_zero) begin
         base = x_ff | y_ff;
      end else if (any_one) begin
         base = DataWidth'(1);
      end else begin
         base = y_ff;
      end
   end

   always_comb begin
      x_in      = x_ff;
      y_in      = y_ff;
      shared_in = shared_ff;
      result_in = result_ff;
      if (cmd.load) begin
         x_in      = operand_a;
         y_in      = operand_b;
         shared_in = '0;
      end else if (cmd.step) begin
         if (!x_ff[0] && !y_ff[0]) begin
            x_in      = x_ff >> 1;
            y_in      = y_ff >> 1;
            shared_in = shared_ff + ShiftWidth'(1);
         end else if (!x_ff[0]) begin
            x_in = x_ff >> 1;
         end else if (!y_ff[0]) begin
            y_in = y_ff >> 1;
         end else if (y_larger) begin
            y_in = x_ff;
            x_in = (y_ff - x_ff) >> 1;
         end else begin
            x_in = (x_ff - y_ff) >> 1;
         end
      end
      if (cmd.finish) begin
         result_in = base << shared_ff;
      end
   end

   always_ff @(posedge clock) begin
      x_ff      <= x_in;
      y_ff      <= y_in;
      shared_ff <= shared_in;
      result_ff <= result_in;
   end

   assign divisor = result_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/bgcd_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bgcd_ctrl
   import bgcd_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire bgcd_sts_type sts,
   output bgcd_cmd_type      cmd,
   output logic              busy,
   output logic              strobe
);

   localparam logic [0:0] StIdle = 1'b0;
   localparam logic [0:0] StRun  = 1'b1;

   logic [0:0] state_ff, state_in;
   logic       strobe_ff, strobe_in;

   always_comb begin
      state_in   = state_ff;
      cmd.load   = 1'b0;
      cmd.step   = 1'b0;
      cmd.finish = 1'b0;
      case (state_ff)
         StIdle: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = StRun;
            end
         end
         StRun: begin
            if (sts.done) begin
               cmd.finish = 1'b1;
               state_in   = StIdle;
            end else begin
               cmd.step = 1'b1;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
      strobe_in = cmd.finish;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= StIdle;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   assign busy   = (state_ff == StRun);
   assign strobe = strobe_ff;

`ifndef SYNTHESIS
   a_accept_runs: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not start a run");

   a_done_strobes: assert property (@(posedge clock) disable iff (reset)
      (busy && sts.done) |=> (strobe && !busy))
      else $error("terminal case did not give a result strobe");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      strobe |-> !busy)
      else $error("result strobe while still running");

   a_strobe_pulse: assert property (@(posedge clock) disable iff (reset)
      strobe |=> !strobe)
      else $error("result strobe longer than one cycle");
`endif

endmodule

`default_nettype wire

// ===== sim/gcd_checker.sv =====
`timescale 1ns / 1ps

module gcd_checker
   import bgcd_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic                 busy,
   input  wire logic [DataWidth-1:0] req_operand_a,
   input  wire logic [DataWidth-1:0] req_operand_b,
   input  wire logic                 rsp_valid,
   input  wire logic [DataWidth-1:0] rsp_divisor,
   output int                        error_count,
   output int                        pending_count
);

   typedef struct {
      logic [DataWidth-1:0] operand_a;
      logic [DataWidth-1:0] operand_b;
      logic [DataWidth-1:0] divisor;
   } gcd_expect_type;

   gcd_expect_type divisor_queue[$];

   // binary gcd with shared factor-of-two count
   function automatic logic [DataWidth-1:0] stein_divisor(input logic [DataWidth-1:0] a,
                                                          input logic [DataWidth-1:0] b);
      logic [DataWidth-1:0] x;
      logic [DataWidth-1:0] y;
      logic [DataWidth-1:0] g;
      logic [DataWidth-1:0] d;
      int                   shared;
      bit                   done;
      x      = a;
      y      = b;
      g      = '0;
      shared = 0;
      done   = 1'b0;
      while (!done) begin
         if (x == 0 || y == 0) begin
            g    = (x > y) ? x : y;
            done = 1'b1;
         end else if (x == 1 || y == 1) begin
            g    = 1;
            done = 1'b1;
         end else if (x == y) begin
            g    = y;
            done = 1'b1;
         end else if (!x[0] && !y[0]) begin
            x      = x >> 1;
            y      = y >> 1;
            shared = shared + 1;
         end else if (!x[0]) begin
            x = x >> 1;
         end else if (!y[0]) begin
            y = y >> 1;
         end else if (y > x) begin
            d = (y - x) >> 1;
            y = x;
            x = d;
         end else begin
            x = (x - y) >> 1;
         end
      end
      return (shared >= DataWidth) ? '0 : (g << shared);
   endfunction

   initial begin
      error_count   = 0;
      pending_count = 0;
   end

   always @(posedge clock) begin
      gcd_expect_type item;
      if (!reset) begin
         if (rsp_valid) begin
            if (divisor_queue.size() == 0) begin
               error_count = error_count + 1;
               if (error_count <= 10)
                  $display("unexpected result transfer: divisor %h", rsp_divisor);
            end else begin
               item = divisor_queue.pop_front();
               if (rsp_divisor !== item.divisor) begin
                  error_count = error_count + 1;
                  if (error_count <= 10)
                     $display("divisor mismatch for a=%h b=%h: expected %h, got %h",
                              item.operand_a, item.operand_b, item.divisor, rsp_divisor);
               end
            end
         end
         if (start && !busy) begin
            item.operand_a = req_operand_a;
            item.operand_b = req_operand_b;
            item.divisor   = stein_divisor(req_operand_a, req_operand_b);
            divisor_queue.push_back(item);
         end
      end
      pending_count = divisor_queue.size();
   end

endmodule

// ===== sim/binary_gcd_tb.sv =====
`timescale 1ns / 1ps

module binary_gcd_tb;
   import bgcd_pkg::*;

   // run length and end-of-run drain
   localparam int CycleLimit   = 1000000;
   localparam int DrainCycles  = 80;
   localparam int PhaseItems   = 225;
   localparam logic [DataWidth-1:0] AllOnes = '1;
   localparam logic [DataWidth-1:0] TopBit  = {1'b1, {(DataWidth-1){1'b0}}};

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [DataWidth-1:0] req_operand_a;
   logic [DataWidth-1:0] req_operand_b;
   logic                 rsp_valid;
   logic [DataWidth-1:0] rsp_divisor;

   int error_count;
   int pending_count;
   int cycle_count;
   // chance in a hundred that the sender idles before a transfer
   int idle_pct;

   binary_gcd u_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_operand_a (req_operand_a),
      .req_operand_b (req_operand_b),
      .rsp_valid     (rsp_valid),
      .rsp_divisor   (rsp_divisor)
   );

   // watches both channels, predicts each divisor and compares
   gcd_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_operand_a (req_operand_a),
      .req_operand_b (req_operand_b),
      .rsp_valid     (rsp_valid),
      .rsp_divisor   (rsp_divisor),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   // 8 ns clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // watchdog on total run length
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // one request transfer, entered and left at a falling edge
   task automatic send_pair(input logic [DataWidth-1:0] a, input logic [DataWidth-1:0] b);
      int gap;
      gap = 0;
      // long gaps too, so that idling lands on every step of the reduction
      if ($urandom_range(99) < idle_pct)
         gap = $urandom_range(1, 80);
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) begin
            // noise on the operand ports while start is low
            req_operand_a = $urandom;
            req_operand_b = $urandom;
            @(negedge clock);
         end
      end
      start         = 1'b1;
      req_operand_a = a;
      req_operand_b = b;
      // hold the request until an edge sees busy low
      @(posedge clock);
      while (busy)
         @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      logic [DataWidth-1:0] a;
      logic [DataWidth-1:0] b;
      logic [DataWidth-1:0] g;
      int                   shift;
      int                   pick;

      // every input known from time zero, reset held high and released at a falling edge
      reset         = 1'b1;
      start         = 1'b0;
      req_operand_a = '0;
      req_operand_b = '0;
      idle_pct      = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: zero operands, unit operands, equal operands, extremes
      send_pair('0, '0);
      send_pair('0, 32'd12345);
      send_pair(32'd98765, '0);
      send_pair('0, AllOnes);
      send_pair(AllOnes, '0);
      send_pair(32'd1, 32'd1);
      send_pair(32'd1, AllOnes);
      send_pair(AllOnes, 32'd1);
      send_pair(AllOnes, AllOnes);
      send_pair(AllOnes, AllOnes - 1);
      send_pair(32'd17, 32'd17);
      // powers of two: longest shared count
      send_pair(TopBit, TopBit);
      send_pair(TopBit, TopBit >> 1);
      send_pair(TopBit, 32'd1);
      send_pair(32'h8000_0000, 32'hC000_0000);
      send_pair(32'd2, 32'd2);
      // both even, one even, both odd with either one the larger
      send_pair(32'd48, 32'd180);
      send_pair(32'd6, 32'd4);
      send_pair(32'd12, 32'd18);
      send_pair(32'd7, 32'd13);
      send_pair(32'd13, 32'd7);
      send_pair(32'hFFFF_FFFB, 32'd3);
      send_pair(32'hAAAA_AAAA, 32'h5555_5555);
      send_pair(32'h5555_5555, 32'hAAAA_AAAA);

      // random part in four idling phases: none, sender 69, none (receiver
      // cannot stall), then sender 17
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            1: idle_pct = 69;
            3: idle_pct = 17;
            default: idle_pct = 0;
         endcase
         for (int n = 0; n < PhaseItems; n++) begin
            pick = $urandom_range(9);
            case (pick)
               0, 1, 2: begin
                  a = $urandom;
                  b = $urandom;
               end
               3, 4: begin
                  // shared factor, sometimes with extra shared powers of two
                  g     = $urandom_range(1, 65535);
                  a     = g * $urandom_range(0, 65535);
                  b     = g * $urandom_range(0, 65535);
                  shift = $urandom_range(0, 8);
                  a     = a << shift;
                  b     = b << shift;
               end
               5: begin
                  a = 1 << $urandom_range(0, DataWidth - 1);
                  b = $urandom << $urandom_range(0, DataWidth - 1);
               end
               6: begin
                  a = $urandom_range(0, 20);
                  b = $urandom_range(0, 20);
               end
               7: begin
                  a = $urandom_range(0, 1);
                  b = $urandom;
               end
               8: begin
                  a = $urandom;
                  b = a;
               end
               default: begin
                  // near-equal operands
                  a = $urandom;
                  b = a ^ $urandom_range(0, 255);
               end
            endcase
            // random operand order
            if ($urandom_range(1))
               send_pair(a, b);
            else
               send_pair(b, a);
         end
      end

      start = 1'b0;

      // drain outstanding results, then wait out DrainCycles for any stray result
      while (pending_count != 0)
         @(negedge clock);
      repeat (DrainCycles) @(negedge clock);

      if (error_count == 0 && pending_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/bgcd_pkg.sv
hw/rtl/bgcd_dp.sv
hw/rtl/bgcd_ctrl.sv
hw/rtl/binary_gcd.sv
sim/gcd_checker.sv
sim/binary_gcd_tb.sv
